// ===== rtl/wsfd_pkg.sv =====
// wsfd_pkg: shared types and constants for the WebSocket frame deframer.
// Holds the parse phase encoding, length codes and the result record.
// No dependencies.
package wsfd_pkg;

	// Parse phase of the byte-serial header/payload walker
	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_PAY  = 3'd4
	} phase_t;

	// 7-bit length codes that announce an extended length field
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// Byte counts of the extended length and masking key fields
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	// One output beat
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_byte;
		logic [3:0] frame_opcode;
		logic       final_fragment;
		logic       last_of_frame;
	} result_t;

endpackage

// ===== rtl/websocket_frame_deframer_top.sv =====
// websocket_frame_deframer_top: byte-serial RFC 6455 frame parser.
// Depends on wsfd_pkg (phase type, length codes, result record).
//
//  channel | signals                                   | dir | beat
//  --------+-------------------------------------------+-----+--------------------------
//  in      | in_valid, in_ready, data_byte             | in  | one received stream byte
//  out     | out_valid, out_ready, payload_byte,       | out | one unmasked payload byte
//          | has_byte, frame_opcode, final_fragment,   |     | or an empty-frame marker
//          | last_of_frame                             |     |
//
// One input beat is taken per cycle while in_ready is high; its result, if any, is
// registered. Of the header bytes, only an empty frame's last gives an output beat.
// A two-entry output buffer (output register plus skid register) lets input run
// while a result waits; in_ready drops only when both entries are full.
// arst_n clears the parse phase, held header fields, counters and valid flags.
module websocket_frame_deframer_top
	import wsfd_pkg::*;
#(
	parameter int LENGTH_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic [3:0] frame_opcode,
	output logic       final_fragment,
	output logic       last_of_frame
);

	// Parser state
	phase_t                   phase_q, phase_n;
	logic [3:0]               opcode_q, opcode_n;
	logic                     fin_q, fin_n;
	logic                     mflag_q, mflag_n;
	logic [3:0]               ext_left_q, ext_left_n;
	logic [LENGTH_BITS-1:0]   len_acc_q, len_acc_n;
	logic [31:0]              mkey_q, mkey_n;
	logic [1:0]               mpos_q, mpos_n;
	logic [LENGTH_BITS-1:0]   remain_q, remain_n;

	// Output buffer
	result_t                  out_q, skid_q, res;
	logic                     out_valid_q, skid_valid_q;
	logic                     res_valid;

	// Shared decode
	logic                     in_fire, out_take;
	logic [6:0]               len_code;
	logic                     code_ext16, code_ext64, code_ext;
	logic                     ext_done;
	logic [3:0]               ext_dec;
	logic [LENGTH_BITS-1:0]   acc_shift, remain_dec, start_len;
	logic [7:0]               key_byte;

	assign in_fire    = in_valid & in_ready;
	assign out_take   = out_valid_q & out_ready;
	assign in_ready   = ~skid_valid_q;

	assign len_code   = data_byte[6:0];
	assign code_ext16 = (len_code == LEN_CODE_EXT16);
	assign code_ext64 = (len_code == LEN_CODE_EXT64);
	assign code_ext   = code_ext16 | code_ext64;
	assign ext_dec    = ext_left_q - 4'd1;
	assign ext_done   = (ext_dec == 4'd0);
	assign acc_shift  = {len_acc_q[LENGTH_BITS-9:0], data_byte};
	assign remain_dec = remain_q - LENGTH_BITS'(1);

	// Length that starts the payload, by phase that completes the header
	always_comb begin
		unique case (phase_q)
			PH_HDR1: start_len = LENGTH_BITS'(len_code);
			PH_EXT:  start_len = acc_shift;
			default: start_len = len_acc_q;
		endcase
	end

	// Key byte for the current payload position, most significant first
	always_comb begin
		unique case (mpos_q)
			2'd0: key_byte = mkey_q[31:24];
			2'd1: key_byte = mkey_q[23:16];
			2'd2: key_byte = mkey_q[15:8];
			2'd3: key_byte = mkey_q[7:0];
			default: key_byte = 8'd0;
		endcase
		if (!mflag_q) begin
			key_byte = 8'd0;
		end
	end

	// Next phase
	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			PH_HDR1: begin
				if (code_ext) begin
					phase_n = PH_EXT;
				end else if (data_byte[7]) begin
					phase_n = PH_KEY;
				end else if (start_len == '0) begin
					phase_n = PH_HDR0;
				end else begin
					phase_n = PH_PAY;
				end
			end
			PH_EXT: begin
				if (ext_done) begin
					if (mflag_q) begin
						phase_n = PH_KEY;
					end else if (start_len == '0) begin
						phase_n = PH_HDR0;
					end else begin
						phase_n = PH_PAY;
					end
				end
			end
			PH_KEY: begin
				if (ext_done) begin
					phase_n = (start_len == '0) ? PH_HDR0 : PH_PAY;
				end
			end
			PH_PAY: begin
				if (remain_dec == '0) begin
					phase_n = PH_HDR0;
				end
			end
			default: phase_n = PH_HDR1;
		endcase
	end

	// Held fields, counters and the result beat
	always_comb begin
		opcode_n   = opcode_q;
		fin_n      = fin_q;
		mflag_n    = mflag_q;
		ext_left_n = ext_left_q;
		len_acc_n  = len_acc_q;
		mkey_n     = mkey_q;
		mpos_n     = mpos_q;
		remain_n   = remain_q;
		res_valid  = 1'b0;
		res.payload_byte   = 8'd0;
		res.has_byte       = 1'b0;
		res.frame_opcode   = opcode_q;
		res.final_fragment = fin_q;
		res.last_of_frame  = 1'b1;

		unique case (phase_q)
			PH_HDR1: begin
				mflag_n   = data_byte[7];
				len_acc_n = '0;
				if (code_ext16) begin
					ext_left_n = EXT16_BYTES;
				end else if (code_ext64) begin
					ext_left_n = EXT64_BYTES;
				end else begin
					len_acc_n = start_len;
					if (data_byte[7]) begin
						mkey_n     = 32'd0;
						ext_left_n = KEY_BYTES;
					end else begin
						mpos_n    = 2'd0;
						remain_n  = start_len;
						res_valid = (start_len == '0);
					end
				end
			end
			PH_EXT: begin
				len_acc_n  = acc_shift;
				ext_left_n = ext_dec;
				if (ext_done) begin
					if (mflag_q) begin
						mkey_n     = 32'd0;
						ext_left_n = KEY_BYTES;
					end else begin
						mpos_n    = 2'd0;
						remain_n  = start_len;
						res_valid = (start_len == '0);
					end
				end
			end
			PH_KEY: begin
				mkey_n     = {mkey_q[23:0], data_byte};
				ext_left_n = ext_dec;
				if (ext_done) begin
					mpos_n    = 2'd0;
					remain_n  = start_len;
					res_valid = (start_len == '0);
				end
			end
			PH_PAY: begin
				mpos_n             = mpos_q + 2'd1;
				remain_n           = remain_dec;
				res_valid          = 1'b1;
				res.payload_byte   = data_byte ^ key_byte;
				res.has_byte       = 1'b1;
				res.last_of_frame  = (remain_dec == '0);
			end
			default: begin
				fin_n    = data_byte[7];
				opcode_n = data_byte[3:0];
			end
		endcase
	end

	// Parser registers, advance on each accepted input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			opcode_q   <= 4'd0;
			fin_q      <= 1'b0;
			mflag_q    <= 1'b0;
			ext_left_q <= 4'd0;
			len_acc_q  <= '0;
			mkey_q     <= 32'd0;
			mpos_q     <= 2'd0;
			remain_q   <= '0;
		end else if (in_fire) begin
			phase_q    <= phase_n;
			opcode_q   <= opcode_n;
			fin_q      <= fin_n;
			mflag_q    <= mflag_n;
			ext_left_q <= ext_left_n;
			len_acc_q  <= len_acc_n;
			mkey_q     <= mkey_n;
			mpos_q     <= mpos_n;
			remain_q   <= remain_n;
		end
	end

	// Output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire && res_valid) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Buffer payload, no reset
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (in_fire && res_valid) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign payload_byte   = out_q.payload_byte;
	assign has_byte       = out_q.has_byte;
	assign frame_opcode   = out_q.frame_opcode;
	assign final_fragment = out_q.final_fragment;
	assign last_of_frame  = out_q.last_of_frame;

endmodule
